// ----- hw/rtl/imu_complementary_yaw_pitch_fusion_unit_assert.svh -----
// Assertion macros used by the fusion unit sequencer (cyp_ctrl).
`ifndef IMU_COMPLEMENTARY_YAW_PITCH_FUSION_UNIT_ASSERT_SVH
`define IMU_COMPLEMENTARY_YAW_PITCH_FUSION_UNIT_ASSERT_SVH
`ifndef SYNTH
`define CYP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define CYP_ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) (!rstn) |=> (prop)) else $error(msg);
`else
`define CYP_ASSERT(lbl, clk, rstn, prop, msg)
`define CYP_ASSERT_RST(lbl, clk, rstn, prop, msg)
`endif
`endif

// ----- hw/rtl/cyp_pkg.sv -----
// Shared types, constants and arithmetic helpers of the yaw/pitch fusion unit.
package cyp_pkg;

    localparam int COUNT_BITS   = 14;
    localparam int CORDIC_STEPS = 20;
    localparam int ITER_W       = 5;

    localparam logic signed [33:0] GYRO_SCALE = 34'sd4806318;
    localparam logic [10:0]        KP_MAX     = 11'd1311;
    localparam logic [31:0]        NORM_SEED  = 32'd3932160;
    localparam logic signed [31:0] HALF_TURN  = 32'sd11796480;

    typedef enum logic [2:0] {
        REG_BIAS_PITCH = 3'd0,
        REG_BIAS_YAW   = 3'd1,
        REG_YAW_GAIN   = 3'd2,
        REG_SLOPE      = 3'd3,
        REG_STILL_THR  = 3'd4,
        REG_BREAK      = 3'd5,
        REG_COMB_TIME  = 3'd6,
        REG_KAL_TIME   = 3'd7
    } t_reg;

    typedef enum logic [1:0] {
        SRC_GYRO = 2'd0,
        SRC_COMB = 2'd1,
        SRC_KAL  = 2'd2,
        SRC_EQ   = 2'd3
    } t_src;

    typedef enum logic [3:0] {
        M_NONE, M_DP, M_DY, M_YA, M_YB, M_SQX, M_SQY, M_SQZ, M_RED, M_PA, M_PB
    } t_mul;

    typedef enum logic [1:0] {
        A_NONE, A_LOAD, A_ADD
    } t_acc;

    typedef enum logic [3:0] {
        W_NONE, W_DP, W_DY, W_CYAW, W_NORM, W_REF, W_DEV, W_KP, W_ACCP, W_CPITCH,
        W_FINAL
    } t_wr;

    typedef struct packed {
        logic              load_in;
        t_mul              mul;
        t_acc              acc;
        t_wr               wr;
        logic              cinit;
        logic              citer;
        logic [ITER_W-1:0] iter;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

    function automatic logic signed [31:0] atan_deg(input logic [ITER_W-1:0] i);
        logic signed [31:0] r;
        case (i)
            5'd0:    r = 32'sd2949120;
            5'd1:    r = 32'sd1740967;
            5'd2:    r = 32'sd919879;
            5'd3:    r = 32'sd466945;
            5'd4:    r = 32'sd234379;
            5'd5:    r = 32'sd117304;
            5'd6:    r = 32'sd58666;
            5'd7:    r = 32'sd29335;
            5'd8:    r = 32'sd14668;
            5'd9:    r = 32'sd7334;
            5'd10:   r = 32'sd3667;
            5'd11:   r = 32'sd1833;
            5'd12:   r = 32'sd917;
            5'd13:   r = 32'sd458;
            5'd14:   r = 32'sd229;
            5'd15:   r = 32'sd115;
            5'd16:   r = 32'sd57;
            5'd17:   r = 32'sd29;
            5'd18:   r = 32'sd14;
            5'd19:   r = 32'sd7;
            default: r = 32'sd0;
        endcase
        return r;
    endfunction

    // round half away from zero, arithmetic shift by s
    function automatic logic signed [67:0] rnd_shift(input logic signed [67:0] v,
                                                     input logic [4:0] s);
        logic signed [67:0] h;
        logic signed [67:0] b;
        h = 68'sd1 <<< (s - 5'd1);
        if (!v[67]) begin
            b = v + h;
        end else begin
            b = v + ((68'sd1 <<< s) - 68'sd1 - h);
        end
        return b >>> s;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [31:0] r;
        if (v > 68'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -68'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/imu_complementary_yaw_pitch_fusion_unit.sv -----
// Top level of the pitch/yaw complementary fusion unit.
// Input channel: i_in_valid / o_in_stall carry one sample (gyro rates, three
// accelerations, magnetometer yaw, external Kalman yaw). A transaction is
// taken when valid is high and stall is low; stall is high while a sample
// is being worked on.
// Output channel: o_out_valid / i_out_stall carry pitch, spliced yaw and the
// yaw source. The result sits in an output register, so the next sample is
// taken while an earlier result still waits.
// Config channel: i_cfg_valid / o_cfg_ready (always ready), index and data;
// write only while the unit is idle.
// Each sample is worked through step by step by the single shared multiplier
// that serves all products in turn and the 20-step CORDIC atan2 unit; the next
// sample is taken only once the current one has been written to the output.
// If the receiver stalls, a finished sample waits in its last step until the
// output register frees, and the input keeps stalling meanwhile.
// Synchronous reset clears the filter state, counters and valid flags and
// loads the configuration defaults.
module imu_complementary_yaw_pitch_fusion_unit
    import cyp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_rate_pitch,
    input  logic signed [31:0] i_rate_yaw,
    input  logic signed [31:0] i_accel_x,
    input  logic signed [31:0] i_accel_y,
    input  logic signed [31:0] i_accel_z,
    input  logic signed [31:0] i_mag_yaw,
    input  logic signed [31:0] i_kalman_yaw,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_pitch_out,
    output logic signed [31:0] o_yaw_out,
    output logic [1:0]         o_yaw_source,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_busy;

    assign o_in_stall  = w_busy;
    assign o_cfg_ready = 1'b1;

    cyp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_busy     (w_busy),
        .o_cmd      (w_cmd)
    );

    cyp_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_cfg_we     (i_cfg_valid && o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_rate_pitch (i_rate_pitch),
        .i_rate_yaw   (i_rate_yaw),
        .i_accel_x    (i_accel_x),
        .i_accel_y    (i_accel_y),
        .i_accel_z    (i_accel_z),
        .i_mag_yaw    (i_mag_yaw),
        .i_kalman_yaw (i_kalman_yaw),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_pitch_out  (o_pitch_out),
        .o_yaw_out    (o_yaw_out),
        .o_yaw_source (o_yaw_source)
    );

endmodule

// ----- hw/rtl/cyp_ctrl.sv -----
// Sequencer that steps the shared multiplier, accumulator and CORDIC.
`include "imu_complementary_yaw_pitch_fusion_unit_assert.svh"
module cyp_ctrl
    import cyp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output logic o_busy,
    output t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_DP, S_DY, S_WDY, S_YA, S_YB, S_YADD, S_YW, S_SQX, S_SQY, S_SQZ,
        S_SQADD, S_NORM, S_REF, S_DEV, S_RED, S_KP, S_CINIT, S_CITER, S_ACCP,
        S_PA, S_PB, S_PADD, S_PW, S_FINAL
    } t_state;

    t_state            r_state, n_state;
    logic [ITER_W-1:0] r_iter, n_iter;
    t_cmd              w_cmd;

    always_comb begin
        w_cmd      = '0;
        w_cmd.mul  = M_NONE;
        w_cmd.acc  = A_NONE;
        w_cmd.wr   = W_NONE;
        w_cmd.iter = r_iter;
        n_state    = r_state;
        n_iter     = r_iter;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load_in = 1'b1;
                    n_state       = S_DP;
                end
            end
            S_DP:    begin w_cmd.mul = M_DP; n_state = S_DY; end
            S_DY:    begin w_cmd.wr = W_DP; w_cmd.mul = M_DY; n_state = S_WDY; end
            S_WDY:   begin w_cmd.wr = W_DY; n_state = S_YA; end
            S_YA:    begin w_cmd.mul = M_YA; n_state = S_YB; end
            S_YB:    begin w_cmd.acc = A_LOAD; w_cmd.mul = M_YB; n_state = S_YADD; end
            S_YADD:  begin w_cmd.acc = A_ADD; n_state = S_YW; end
            S_YW:    begin w_cmd.wr = W_CYAW; n_state = S_SQX; end
            S_SQX:   begin w_cmd.mul = M_SQX; n_state = S_SQY; end
            S_SQY:   begin w_cmd.acc = A_LOAD; w_cmd.mul = M_SQY; n_state = S_SQZ; end
            S_SQZ:   begin w_cmd.acc = A_ADD; w_cmd.mul = M_SQZ; n_state = S_SQADD; end
            S_SQADD: begin w_cmd.acc = A_ADD; n_state = S_NORM; end
            S_NORM:  begin w_cmd.wr = W_NORM; n_state = S_REF; end
            S_REF:   begin w_cmd.wr = W_REF; n_state = S_DEV; end
            S_DEV:   begin w_cmd.wr = W_DEV; n_state = S_RED; end
            S_RED:   begin w_cmd.mul = M_RED; n_state = S_KP; end
            S_KP:    begin w_cmd.wr = W_KP; n_state = S_CINIT; end
            S_CINIT: begin
                w_cmd.cinit = 1'b1;
                n_iter      = '0;
                n_state     = S_CITER;
            end
            S_CITER: begin
                w_cmd.citer = 1'b1;
                n_iter      = r_iter + 1'b1;
                if (r_iter == ITER_W'(CORDIC_STEPS - 1)) begin
                    n_state = S_ACCP;
                end
            end
            S_ACCP:  begin w_cmd.wr = W_ACCP; n_state = S_PA; end
            S_PA:    begin w_cmd.mul = M_PA; n_state = S_PB; end
            S_PB:    begin w_cmd.acc = A_LOAD; w_cmd.mul = M_PB; n_state = S_PADD; end
            S_PADD:  begin w_cmd.acc = A_ADD; n_state = S_PW; end
            S_PW:    begin w_cmd.wr = W_CPITCH; n_state = S_FINAL; end
            S_FINAL: begin
                if (i_sts.out_free) begin
                    w_cmd.wr = W_FINAL;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
        end
    end

    assign o_cmd  = w_cmd;
    assign o_busy = (r_state != S_IDLE);

    `CYP_ASSERT(a_iter_range, i_clk, i_rst_n, (r_state == S_CITER) |-> (r_iter < ITER_W'(CORDIC_STEPS)), "CORDIC step count out of range")
    `CYP_ASSERT(a_start, i_clk, i_rst_n, ((r_state == S_IDLE) && i_in_valid) |=> (r_state == S_DP), "transaction accepted without starting")
    `CYP_ASSERT(a_final, i_clk, i_rst_n, (w_cmd.wr == W_FINAL) |-> i_sts.out_free, "result written while output is held")
    `CYP_ASSERT_RST(a_reset_idle, i_clk, i_rst_n, (r_state == S_IDLE), "not idle after reset")

endmodule

// ----- hw/rtl/cyp_dp.sv -----
// Datapath: configuration registers, filter state, shared multiplier, CORDIC.
module cyp_dp
    import cyp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic signed [31:0] i_rate_pitch,
    input  logic signed [31:0] i_rate_yaw,
    input  logic signed [31:0] i_accel_x,
    input  logic signed [31:0] i_accel_y,
    input  logic signed [31:0] i_accel_z,
    input  logic signed [31:0] i_mag_yaw,
    input  logic signed [31:0] i_kalman_yaw,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic signed [31:0] o_pitch_out,
    output logic signed [31:0] o_yaw_out,
    output logic [1:0]         o_yaw_source
);

    logic signed [31:0] r_bias_p, r_bias_y;
    logic [15:0]        r_ymg, r_slope;
    logic [30:0]        r_thr;
    logic [13:0]        r_break, r_comb_time, r_kal_time;

    logic signed [31:0] r_rp, r_ry, r_ax, r_ay, r_az, r_mag, r_kal;

    logic signed [31:0]    r_comb_yaw, r_comb_pitch, r_prev_comb, r_prev_kal;
    logic [31:0]           r_spliced, r_ref;
    logic [COUNT_BITS-1:0] r_still, r_motion;
    logic                  r_seeded;

    logic signed [67:0] r_prod, r_acc;
    logic signed [31:0] r_dp, r_dy, r_accp;
    logic [31:0]        r_norm, r_dev;
    logic [10:0]        r_kp;
    logic signed [35:0] r_x, r_y;
    logic signed [31:0] r_z;
    logic               r_czero;

    logic               r_out_valid;
    logic signed [31:0] r_pitch_out, r_yaw_out;
    logic [1:0]         r_src;

    logic signed [33:0] w_ma, w_mb;
    logic signed [67:0] w_nq, w_red, w_rs24;
    logic signed [35:0] w_xs, w_ys, w_ex, w_ey;
    logic [31:0]        w_mry, w_thr, w_delta;
    logic [COUNT_BITS-1:0] w_still, w_motion;
    t_src               w_src;
    logic               w_out_free;

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (i_cmd.mul)
            M_DP: begin w_ma = 34'(r_rp) - 34'(r_bias_p); w_mb = GYRO_SCALE; end
            M_DY: begin w_ma = 34'(r_ry) - 34'(r_bias_y); w_mb = GYRO_SCALE; end
            M_YA: begin
                w_ma = 34'(r_comb_yaw) + 34'(r_dy);
                w_mb = $signed(34'(17'h10000 - 17'(r_ymg)));
            end
            M_YB: begin w_ma = 34'(r_mag); w_mb = $signed(34'(r_ymg)); end
            M_SQX: begin w_ma = 34'(r_ax); w_mb = 34'(r_ax); end
            M_SQY: begin w_ma = 34'(r_ay); w_mb = 34'(r_ay); end
            M_SQZ: begin w_ma = 34'(r_az); w_mb = 34'(r_az); end
            M_RED: begin w_ma = $signed(34'(r_slope)); w_mb = $signed(34'(r_dev)); end
            M_PA: begin
                w_ma = 34'(r_comb_pitch) + 34'(r_dp);
                w_mb = $signed(34'(17'h10000 - 17'(r_kp)));
            end
            M_PB: begin w_ma = 34'(r_accp); w_mb = $signed(34'(r_kp)); end
            default: begin w_ma = '0; w_mb = '0; end
        endcase
    end

    assign w_nq   = (r_acc + 68'sd32768) >>> 16;
    assign w_red  = (r_prod + 68'sd32768) >>> 16;
    assign w_rs24 = rnd_shift(r_prod, 5'd24);
    assign w_xs   = r_x >>> i_cmd.iter;
    assign w_ys   = r_y >>> i_cmd.iter;
    assign w_ex   = 36'(r_az);
    assign w_ey   = 36'(r_ax);

    assign w_mry = r_ry[31] ? (32'd0 - 32'(r_ry)) : 32'(r_ry);
    assign w_thr = {1'b0, r_thr};

    always_comb begin
        w_still  = r_still;
        w_motion = r_motion;
        w_src    = SRC_EQ;
        w_delta  = r_dy;
        if (w_mry > w_thr) begin
            if (32'(r_motion) > 32'(r_break)) begin
                w_src   = SRC_GYRO;
                w_delta = r_dy;
                w_still = '0;
            end else begin
                w_src   = SRC_COMB;
                w_delta = r_comb_yaw - r_prev_comb;
            end
            w_motion = (&r_motion) ? r_motion : r_motion + 1'b1;
        end else if (w_mry < w_thr) begin
            w_still = (&r_still) ? r_still : r_still + 1'b1;
            if ((32'(w_still) > 32'(r_comb_time)) && (32'(w_still) < 32'(r_kal_time))) begin
                w_src   = SRC_COMB;
                w_delta = r_comb_yaw - r_prev_comb;
            end else if (32'(w_still) >= 32'(r_kal_time)) begin
                w_src   = SRC_KAL;
                w_delta = r_kal - r_prev_kal;
            end else begin
                w_src   = SRC_GYRO;
                w_delta = r_dy;
            end
            w_motion = '0;
        end
    end

    assign w_out_free     = !r_out_valid || !i_out_stall;
    assign o_sts.out_free = w_out_free;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias_p    <= '0;
            r_bias_y    <= '0;
            r_ymg       <= 16'd1311;
            r_slope     <= 16'd328;
            r_thr       <= 31'd3932;
            r_break     <= 14'd5;
            r_comb_time <= 14'd100;
            r_kal_time  <= 14'd5000;
        end else if (i_cfg_we) begin
            case (t_reg'(i_cfg_index))
                REG_BIAS_PITCH: r_bias_p    <= i_cfg_data;
                REG_BIAS_YAW:   r_bias_y    <= i_cfg_data;
                REG_YAW_GAIN:   r_ymg       <= i_cfg_data[15:0];
                REG_SLOPE:      r_slope     <= i_cfg_data[15:0];
                REG_STILL_THR:  r_thr       <= i_cfg_data[30:0];
                REG_BREAK:      r_break     <= i_cfg_data[13:0];
                REG_COMB_TIME:  r_comb_time <= i_cfg_data[13:0];
                REG_KAL_TIME:   r_kal_time  <= i_cfg_data[13:0];
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_rp  <= i_rate_pitch;
            r_ry  <= i_rate_yaw;
            r_ax  <= i_accel_x;
            r_ay  <= i_accel_y;
            r_az  <= i_accel_z;
            r_mag <= i_mag_yaw;
            r_kal <= i_kalman_yaw;
        end
        r_prod <= w_ma * w_mb;
        case (i_cmd.acc)
            A_LOAD:  r_acc <= r_prod;
            A_ADD:   r_acc <= r_acc + r_prod;
            default: ;
        endcase
        case (i_cmd.wr)
            W_DP:   r_dp <= w_rs24[31:0];
            W_DY:   r_dy <= w_rs24[31:0];
            W_NORM: r_norm <= (|w_nq[67:32]) ? 32'hffffffff : w_nq[31:0];
            W_DEV:  r_dev <= (r_norm > r_ref) ? r_norm - r_ref : r_ref - r_norm;
            W_KP:   r_kp <= (w_red >= 68'(KP_MAX)) ? 11'd0 : KP_MAX - w_red[10:0];
            W_ACCP: r_accp <= r_czero ? 32'sd0 : -r_z;
            default: ;
        endcase
        if (i_cmd.cinit) begin
            r_czero <= (r_ax == 32'sd0) && (r_az == 32'sd0);
            if (r_az[31]) begin
                r_x <= -w_ex;
                r_y <= -w_ey;
                r_z <= r_ax[31] ? -HALF_TURN : HALF_TURN;
            end else begin
                r_x <= w_ex;
                r_y <= w_ey;
                r_z <= '0;
            end
        end else if (i_cmd.citer) begin
            if (!r_y[35]) begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + atan_deg(i_cmd.iter);
            end else begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - atan_deg(i_cmd.iter);
            end
        end
    end

    // filter state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_comb_yaw   <= '0;
            r_comb_pitch <= '0;
            r_prev_comb  <= '0;
            r_prev_kal   <= '0;
            r_spliced    <= '0;
            r_ref        <= '0;
            r_still      <= '0;
            r_motion     <= '0;
            r_seeded     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            case (i_cmd.wr)
                W_CYAW:   r_comb_yaw <= sat32(rnd_shift(r_acc, 5'd16));
                W_REF:    if (r_ref < NORM_SEED) r_ref <= r_norm;
                W_CPITCH: r_comb_pitch <= sat32(rnd_shift(r_acc, 5'd16));
                W_FINAL: begin
                    r_spliced   <= r_spliced + w_delta;
                    r_prev_comb <= r_comb_yaw;
                    r_prev_kal  <= r_kal;
                    r_still     <= w_still;
                    r_motion    <= w_motion;
                    if (!r_seeded) begin
                        r_comb_yaw   <= r_mag;
                        r_comb_pitch <= r_accp;
                        r_ref        <= r_norm;
                        r_seeded     <= 1'b1;
                    end
                end
                default: ;
            endcase
            if (i_cmd.wr == W_FINAL) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr == W_FINAL) begin
            r_pitch_out <= r_seeded ? r_comb_pitch : r_accp;
            r_yaw_out   <= r_spliced + w_delta;
            r_src       <= w_src;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pitch_out  = r_pitch_out;
    assign o_yaw_out    = r_yaw_out;
    assign o_yaw_source = r_src;

endmodule
